/* design/zsr_pkg.sv */
// Package for the ZMODEM subpacket receiver: payload structs, codes, line
// characters and the bytewise CRC-16 / CRC-32 update functions.
// No dependencies.
package zsr_pkg;

  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CNT_MAX     = (1 << CNT_W) - 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZDLE  = 8'h18;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_ZCRCE = 8'h68;
  localparam logic [7:0] CH_ZCRCW = 8'h6B;
  localparam logic [7:0] CH_RUB0  = 8'h6C;
  localparam logic [7:0] CH_RUB1  = 8'h6D;
  localparam logic [7:0] ESC_MASK = 8'h60;
  localparam logic [7:0] ESC_SEL  = 8'h40;
  localparam logic [7:0] ESC_FLIP = 8'h40;

  localparam logic [31:0] CRC32_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_RESIDUE = 32'hDEBB_20E3;
  localparam logic [31:0] CRC32_POLY    = 32'hEDB8_8320;
  localparam logic [15:0] CRC16_POLY    = 16'h1021;

  localparam logic [2:0] TRAILER_LEN16 = 3'd2;
  localparam logic [2:0] TRAILER_LEN32 = 3'd4;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_CARRIER = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RES_DATA = 2'd0,
    RES_GOOD = 2'd1,
    RES_FAIL = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    WHY_CRC     = 3'd0,
    WHY_LONG    = 3'd1,
    WHY_CANCEL  = 3'd2,
    WHY_TIMEOUT = 3'd3,
    WHY_CARRIER = 3'd4,
    WHY_ESCAPE  = 3'd5
  } why_t;

  typedef enum logic {
    REG_CRC32_MODE = 1'b0,
    REG_MAX_LEN    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_FEND = 2'd1,
    OP_FAIL = 2'd2
  } op_kind_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       data_byte;
    logic [1:0]       frame_end;
    logic [2:0]       fail_reason;
    logic [CNT_W-1:0] byte_count;
  } out_item_t;

  // Classified operation handed from the front end to the back end.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic [1:0] code;
    why_t       why;
  } op_t;

  // Configuration and re-arm control from the top level to the back end.
  typedef struct packed {
    logic             crc32_mode;
    logic [CNT_W-1:0] max_len;
    logic             rearm;
    logic             rearm_mode;
  } ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

endpackage

/* design/zsr_front.sv */
// Front end of the subpacket receiver: accepts line requests, undoes the
// escape coding and turns each request into at most one queued operation.
// Depends on zsr_pkg.
module zsr_front import zsr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     queue_full,
  input  logic     rearm,
  output logic     push,
  output op_t      push_op
);

  logic       esc_r, esc_nxt;
  logic [1:0] can_r, can_nxt;
  logic       accept;
  logic [7:0] b;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.line_byte;

  always_comb begin
    esc_nxt      = esc_r;
    can_nxt      = can_r;
    push         = 1'b0;
    push_op.kind = OP_DATA;
    push_op.data = b;
    push_op.code = 2'd0;
    push_op.why  = WHY_CRC;
    if (rearm) begin
      esc_nxt = 1'b0;
      can_nxt = 2'd0;
    end else if (accept) begin
      case (in_item.command)
        CMD_TIMEOUT, CMD_CARRIER: begin
          push         = 1'b1;
          push_op.kind = OP_FAIL;
          push_op.why  = (in_item.command == CMD_TIMEOUT) ? WHY_TIMEOUT : WHY_CARRIER;
          esc_nxt      = 1'b0;
          can_nxt      = 2'd0;
        end
        CMD_BYTE: begin
          if (!esc_r) begin
            if (b == CH_ZDLE) begin
              esc_nxt = 1'b1;
              can_nxt = 2'd0;
            end else begin
              push = 1'b1;
            end
          end else if (b == CH_CAN) begin
            // Up to three CANs after ZDLE are skipped; the fourth cancels.
            if (can_r != 2'd3) begin
              can_nxt = can_r + 2'd1;
            end else begin
              push         = 1'b1;
              push_op.kind = OP_FAIL;
              push_op.why  = WHY_CANCEL;
              esc_nxt      = 1'b0;
              can_nxt      = 2'd0;
            end
          end else begin
            esc_nxt = 1'b0;
            can_nxt = 2'd0;
            push    = 1'b1;
            if (b inside {[CH_ZCRCE:CH_ZCRCW]}) begin
              push_op.kind = OP_FEND;
              push_op.code = 2'(b - CH_ZCRCE);
            end else if (b == CH_RUB0) begin
              push_op.data = 8'h7F;
            end else if (b == CH_RUB1) begin
              push_op.data = 8'hFF;
            end else if ((b & ESC_MASK) == ESC_SEL) begin
              push_op.data = b ^ ESC_FLIP;
            end else begin
              push_op.kind = OP_FAIL;
              push_op.why  = WHY_ESCAPE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      can_r <= 2'd0;
    end else begin
      esc_r <= esc_nxt;
      can_r <= can_nxt;
    end
  end

endmodule

/* design/zsr_queue.sv */
// Short operation queue between the front and back ends of the receiver.
// Depends on zsr_pkg.
module zsr_queue import zsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output op_t  head_op
);

  op_t               entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/zsr_back.sv */
// Back end of the receiver: runs the CRC, byte count, length limit and
// trailer check for each queued operation and holds the result register.
// Depends on zsr_pkg.
module zsr_back import zsr_pkg::*; #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctrl,
  input  logic      head_valid,
  input  op_t       head_op,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [CNT_W-1:0] LIMIT_CAP =
    (MAX_PACKET > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_PACKET);

  logic             trl_r, trl_nxt;
  logic [2:0]       left_r, left_nxt;
  logic [1:0]       end_r, end_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             slot_free;
  logic             res_valid;
  out_item_t        res;
  logic [31:0]      crc_fold;
  logic [CNT_W-1:0] limit;
  logic [2:0]       left_dec;
  logic             crc_good;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = head_valid && slot_free;
  assign limit     = (ctrl.max_len > LIMIT_CAP) ? LIMIT_CAP : ctrl.max_len;
  assign crc_fold  = ctrl.crc32_mode ? crc32_byte(crc_r, head_op.data)
                                     : {16'h0, crc16_byte(crc_r[15:0], head_op.data)};
  assign left_dec  = (left_r != 3'd0) ? left_r - 3'd1 : left_r;
  assign crc_good  = ctrl.crc32_mode ? (crc_fold == CRC32_RESIDUE) : (crc_fold[15:0] == 16'h0);

  always_comb begin
    trl_nxt         = trl_r;
    left_nxt        = left_r;
    end_nxt         = end_r;
    crc_nxt         = crc_r;
    cnt_nxt         = cnt_r;
    res_valid       = 1'b0;
    res.result_kind = RES_FAIL;
    res.data_byte   = 8'h00;
    res.frame_end   = 2'd0;
    res.fail_reason = WHY_CRC;
    res.byte_count  = cnt_r;
    if (ctrl.rearm) begin
      trl_nxt  = 1'b0;
      left_nxt = 3'd0;
      end_nxt  = 2'd0;
      cnt_nxt  = '0;
      crc_nxt  = ctrl.rearm_mode ? CRC32_INIT : 32'h0;
    end else if (pop) begin
      case (head_op.kind)
        OP_FAIL: begin
          res_valid       = 1'b1;
          res.fail_reason = head_op.why;
        end
        OP_FEND: begin
          end_nxt  = head_op.code;
          crc_nxt  = crc_fold;
          trl_nxt  = 1'b1;
          left_nxt = ctrl.crc32_mode ? TRAILER_LEN32 : TRAILER_LEN16;
        end
        OP_DATA: begin
          if (trl_r) begin
            crc_nxt  = crc_fold;
            left_nxt = left_dec;
            if (left_dec == 3'd0) begin
              res_valid       = 1'b1;
              res.frame_end   = end_r;
              res.result_kind = crc_good ? RES_GOOD : RES_FAIL;
            end
          end else if (cnt_r >= limit) begin
            res_valid       = 1'b1;
            res.fail_reason = WHY_LONG;
          end else begin
            cnt_nxt         = cnt_r + CNT_W'(1);
            crc_nxt         = crc_fold;
            res_valid       = 1'b1;
            res.result_kind = RES_DATA;
            res.data_byte   = head_op.data;
            res.byte_count  = cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      // Any packet-level result re-arms for the next subpacket.
      if (res_valid && res.result_kind != RES_DATA) begin
        trl_nxt  = 1'b0;
        left_nxt = 3'd0;
        end_nxt  = 2'd0;
        cnt_nxt  = '0;
        crc_nxt  = ctrl.crc32_mode ? CRC32_INIT : 32'h0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (slot_free) begin
      out_valid_nxt = res_valid;
      out_item_nxt  = res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trl_r       <= 1'b0;
      left_r      <= 3'd0;
      end_r       <= 2'd0;
      crc_r       <= 32'h0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      trl_r       <= trl_nxt;
      left_r      <= left_nxt;
      end_r       <= end_nxt;
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/zmodem_subpacket_receiver.sv */
// Top level of the ZMODEM data subpacket receiver: configuration registers
// and the front end, operation queue and back end.
// Depends on zsr_pkg, zsr_front, zsr_queue and zsr_back.
//
//   channel   direction  handshake          payload
//   in_       in         in_valid/in_stall  in_item  (command, line_byte)
//   out_      out        out_valid/out_stall out_item (kind, byte, end, reason, count)
//   cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request is classified and written into the queue at the edge that accepts it.
// The back end takes it from the queue head when the output register is free and loads
// its result into the output register at the edge that pops it. One request per cycle
// is sustained while out_stall stays low. Synchronous active-low reset clears all
// control state and loads CRC-16 mode with a limit of 1024 bytes; a stalled output
// fills the two-entry queue.
module zmodem_subpacket_receiver import zsr_pkg::*; #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] max_len_r, max_len_nxt;
  logic             cfg_write;
  logic             rearm;
  ctrl_t            ctrl;

  logic             push;
  op_t              push_op;
  logic             queue_full;
  logic             head_valid;
  op_t              head_op;
  logic             pop;

  // Always taken; the user ensures configuration arrives only while the block is idle.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Writing the CRC mode drops any packet in progress and re-arms both ends
  // with the initial CRC value of the new mode.
  assign rearm = cfg_write && (cfg_index == REG_CRC32_MODE);

  always_comb begin
    mode_nxt    = mode_r;
    max_len_nxt = max_len_r;
    if (cfg_write) begin
      case (cfg_index)
        REG_CRC32_MODE: mode_nxt    = cfg_data[0];
        REG_MAX_LEN:    max_len_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      max_len_r <= CNT_W'(1024);
    end else begin
      mode_r    <= mode_nxt;
      max_len_r <= max_len_nxt;
    end
  end

  assign ctrl.crc32_mode = mode_r;
  assign ctrl.max_len    = max_len_r;
  assign ctrl.rearm      = rearm;
  assign ctrl.rearm_mode = mode_nxt;

  zsr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .queue_full (queue_full),
    .rearm      (rearm),
    .push       (push),
    .push_op    (push_op)
  );

  zsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  zsr_back #(
    .MAX_PACKET (MAX_PACKET)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
